// ===== rtl/core/bafs_pkg.sv =====
// Shared types and codes of the batched acknowledged frame sender.
package bafs_pkg;

  localparam int MOD_XW = 13;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_DISC  = 2'd3;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_NOCAP = 2'd3;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_NOCAP = 3'd1;
  localparam logic [2:0] OP_ACK   = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_DISC  = 3'd4;

  localparam logic [1:0] REG_BATCH_FRAMES  = 2'd0;
  localparam logic [1:0] REG_MAX_ATTEMPTS  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;
  localparam logic [1:0] REG_PRE_TRIGGER   = 2'd3;

  localparam logic [4:0]  RST_BATCH_FRAMES  = 5'd4;
  localparam logic [3:0]  RST_MAX_ATTEMPTS  = 4'd4;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd300;
  localparam logic [10:0] RST_PRE_TRIGGER   = 11'd960;

  typedef struct packed {
    logic [2:0]  op;
    logic [10:0] trig;
    logic        has_last;
    logic [15:0] ack_last;
  } bafs_cmd_t;

  typedef struct packed {
    logic      valid;
    bafs_cmd_t cmd;
  } bafs_q_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [15:0] wdata;
  } bafs_cfg_t;

  typedef struct packed {
    logic              start;
    logic [MOD_XW-1:0] x;
  } bafs_mod_req_t;

  typedef struct packed {
    logic              done;
    logic [MOD_XW-1:0] r;
  } bafs_mod_rsp_t;

endpackage

// ===== rtl/core/bafs_channels.sv =====
// Valid/ready channel interfaces for command words and result words.
interface bafs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        has_capture;
  logic [10:0] trigger_index;
  logic        ack_has_last;
  logic [15:0] ack_last;
  modport source (output valid, command, has_capture, trigger_index, ack_has_last, ack_last,
                  input ready);
  modport sink (input valid, command, has_capture, trigger_index, ack_has_last, ack_last,
                output ready);
endinterface

interface bafs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         frame_number;
  logic [3:0]         sample_count;
  logic [10:0]        first_ring_index;
  logic signed [11:0] first_sample_offset;
  logic [7:0]         total_frames;
  logic               last;
  modport source (output valid, kind, frame_number, sample_count, first_ring_index,
                  first_sample_offset, total_frames, last, input ready);
  modport sink (input valid, kind, frame_number, sample_count, first_ring_index,
                first_sample_offset, total_frames, last, output ready);
endinterface

// ===== rtl/core/batched_ack_frame_sender_top.sv =====
// Top level of the batched acknowledged frame sender.
//
//   channel  direction  handshake        word
//   in_ch    in         valid/ready      command, capture, trigger, ack fields
//   out_ch   out        valid/ready      kind, frame descriptor, total, last
//   cfg_*    in         write enable     register index and write data
//
// An item waits in a two-word queue; each reduction modulo the ring depth
// is registered in the shared reducer.
// Within a batch, one result word leaves per cycle when out_ch is ready.
// Reset is synchronous; a stalled out_ch holds the back end while the queue fills.
module batched_ack_frame_sender_top import bafs_pkg::*; #(
  parameter int RING_DEPTH        = 1920,
  parameter int SAMPLES_PER_FRAME = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  bafs_in_if.sink     in_ch,
  bafs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  bafs_q_t       q;
  logic          pop;
  bafs_cfg_t     cfg;
  bafs_mod_req_t mod_req;
  bafs_mod_rsp_t mod_rsp;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  bafs_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .q     (q)
  );

  bafs_modred #(
    .RING_DEPTH (RING_DEPTH)
  ) u_modred (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  bafs_back #(
    .RING_DEPTH        (RING_DEPTH),
    .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q       (q),
    .pop     (pop),
    .cfg     (cfg),
    .mod_req (mod_req),
    .mod_rsp (mod_rsp),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/core/bafs_front.sv =====
// Front end: accepts command words, classifies them and queues them.
module bafs_front import bafs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  bafs_in_if.sink in_ch,
  input  logic    pop,
  output bafs_q_t q
);

  bafs_cmd_t  entry_r [2];
  bafs_cmd_t  cls;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       take;

  always_comb begin
    cls.trig     = in_ch.trigger_index;
    cls.has_last = in_ch.ack_has_last;
    cls.ack_last = in_ch.ack_last;
    case (in_ch.command)
      CMD_START: cls.op = in_ch.has_capture ? OP_START : OP_NOCAP;
      CMD_ACK:   cls.op = OP_ACK;
      CMD_TICK:  cls.op = OP_TICK;
      default:   cls.op = OP_DISC;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign take        = pop && (cnt_r != 2'd0);
  assign q.valid     = (cnt_r != 2'd0);
  assign q.cmd       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/core/bafs_modred.sv =====
// Reduction modulo the ring depth by conditional subtracts of the scaled depth, registered.
module bafs_modred import bafs_pkg::*; #(
  parameter int RING_DEPTH = 1920
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bafs_mod_req_t req,
  output bafs_mod_rsp_t rsp
);

  localparam int CEIL_Q    = ((1 << MOD_XW) + RING_DEPTH - 1) / RING_DEPTH;
  localparam int STEPS_RAW = $clog2(CEIL_Q);
  localparam int MOD_STEPS = (STEPS_RAW < 1) ? 1 : STEPS_RAW;
  localparam int DW        = MOD_XW + 1;
  localparam logic [DW-1:0] D_TOP = DW'(RING_DEPTH * (2 ** (MOD_STEPS - 1)));

  logic [MOD_XW-1:0] x_r, x_nxt;
  logic              done_r, done_nxt;
  logic [DW-1:0]     acc;
  logic [DW-1:0]     d;

  always_comb begin
    acc = {1'b0, req.x};
    d   = D_TOP;
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (acc >= d) begin
        acc = acc - d;
      end
      d = d >> 1;
    end
    x_nxt    = acc[MOD_XW-1:0];
    done_nxt = req.start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= x_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.r    = x_r;

endmodule

// ===== rtl/core/bafs_back.sv =====
// Back end: transfer state, configuration registers and result word sequencing.
module bafs_back import bafs_pkg::*; #(
  parameter int RING_DEPTH        = 1920,
  parameter int SAMPLES_PER_FRAME = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bafs_q_t       q,
  output logic          pop,
  input  bafs_cfg_t     cfg,
  output bafs_mod_req_t mod_req,
  input  bafs_mod_rsp_t mod_rsp,
  bafs_out_if.source    out_ch
);

  localparam int TOT_RAW = (RING_DEPTH + SAMPLES_PER_FRAME - 1) / SAMPLES_PER_FRAME;
  localparam logic [7:0] TOTAL = 8'((TOT_RAW > 255) ? 255 : TOT_RAW);
  localparam int RI_W = $clog2(RING_DEPTH);
  localparam logic [RI_W:0] DEPTH_W = (RI_W + 1)'(RING_DEPTH);
  localparam logic [RI_W:0] SPF_MOD = (RI_W + 1)'(SAMPLES_PER_FRAME % RING_DEPTH);
  localparam logic [MOD_XW-1:0] SPF_X   = MOD_XW'(SAMPLES_PER_FRAME);
  localparam logic [MOD_XW-1:0] DEPTH_X = MOD_XW'(RING_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1;
  localparam logic [2:0] S_TRIG  = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_RI    = 3'd4;
  localparam logic [2:0] S_FRAME = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_number;
    logic [3:0]  sample_count;
    logic [10:0] first_ring_index;
    logic [11:0] first_sample_offset;
    logic [7:0]  total_frames;
    logic        last;
  } bafs_res_t;

  logic [2:0]      state_r, state_nxt;
  bafs_cmd_t       cur_r, cur_nxt;
  logic            active_r, active_nxt;
  logic [RI_W-1:0] ring_start_r, ring_start_nxt;
  logic [7:0]      next_frame_r, next_frame_nxt;
  logic [7:0]      batch_end_r, batch_end_nxt;
  logic [3:0]      attempt_r, attempt_nxt;
  logic [15:0]     wait_r, wait_nxt;
  logic [15:0]     ack_seen_r, ack_seen_nxt;
  logic [RI_W-1:0] pre_mod_r, pre_mod_nxt;
  logic [7:0]      frame_r, frame_nxt;
  logic [RI_W-1:0] ri_r, ri_nxt;
  logic [1:0]      done_kind_r, done_kind_nxt;
  logic [4:0]      batch_frames_r, batch_frames_nxt;
  logic [3:0]      max_attempts_r, max_attempts_nxt;
  logic [15:0]     timeout_ticks_r, timeout_ticks_nxt;
  logic [10:0]     pre_trigger_r, pre_trigger_nxt;
  bafs_res_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [3:0]        lim_att;
  logic [15:0]       lim_to;
  logic [4:0]        b_clamp;
  logic [15:0]       seen_new;
  logic [16:0]       seen_p1;
  logic [7:0]        nf_ack;
  logic [8:0]        be_sum;
  logic [7:0]        be_ack;
  logic [7:0]        be_start;
  logic [16:0]       wait_p1;
  logic              timeout;
  logic [MOD_XW-1:0] ri_x;
  logic [MOD_XW-1:0] fs_cur;
  logic [MOD_XW-1:0] rem;
  logic [MOD_XW-1:0] cnt;
  logic [MOD_XW-1:0] off;
  logic [RI_W-1:0]   trig_mod;
  logic [RI_W:0]     rs_sum;
  logic [RI_W-1:0]   rs;
  logic [RI_W:0]     ri_sum;
  logic [RI_W-1:0]   ri_adv;
  logic              slot;
  logic              last_frame;

  always_comb begin
    lim_att  = (max_attempts_r == 4'd0) ? 4'd1 : max_attempts_r;
    lim_to   = (timeout_ticks_r == 16'd0) ? 16'd1 : timeout_ticks_r;
    if (batch_frames_r == 5'd0) begin
      b_clamp = 5'd1;
    end else if (batch_frames_r > 5'd16) begin
      b_clamp = 5'd16;
    end else begin
      b_clamp = batch_frames_r;
    end
    seen_new = q.cmd.has_last ? q.cmd.ack_last : ack_seen_r;
    seen_p1  = {1'b0, seen_new} + 17'd1;
    nf_ack   = (seen_p1 >= {9'd0, batch_end_r}) ? batch_end_r : seen_p1[7:0];
    be_sum   = {1'b0, nf_ack} + 9'(b_clamp);
    be_ack   = (be_sum < {1'b0, TOTAL}) ? be_sum[7:0] : TOTAL;
    be_start = (9'(b_clamp) < {1'b0, TOTAL}) ? 8'(b_clamp) : TOTAL;
    wait_p1  = {1'b0, wait_r} + 17'd1;
    timeout  = (wait_p1 >= {1'b0, lim_to});
    ri_x     = MOD_XW'(ring_start_r) + MOD_XW'(next_frame_r) * SPF_X;
    fs_cur   = MOD_XW'(frame_r) * SPF_X;
    rem      = (fs_cur < DEPTH_X) ? (DEPTH_X - fs_cur) : '0;
    cnt      = (rem < SPF_X) ? rem : SPF_X;
    off      = fs_cur - MOD_XW'(pre_mod_r);
    trig_mod = mod_rsp.r[RI_W-1:0];
    rs_sum   = (trig_mod >= pre_mod_r) ? ((RI_W + 1)'(trig_mod) - (RI_W + 1)'(pre_mod_r))
                                       : ((RI_W + 1)'(trig_mod) + DEPTH_W
                                          - (RI_W + 1)'(pre_mod_r));
    rs       = rs_sum[RI_W-1:0];
    ri_sum   = (RI_W + 1)'(ri_r) + SPF_MOD;
    ri_adv   = (ri_sum >= DEPTH_W) ? RI_W'(ri_sum - DEPTH_W) : ri_sum[RI_W-1:0];
    slot     = !out_valid_r || out_ch.ready;
    last_frame = (({1'b0, frame_r} + 9'd1) == {1'b0, batch_end_r});
  end

  always_comb begin
    state_nxt         = state_r;
    cur_nxt           = cur_r;
    active_nxt        = active_r;
    ring_start_nxt    = ring_start_r;
    next_frame_nxt    = next_frame_r;
    batch_end_nxt     = batch_end_r;
    attempt_nxt       = attempt_r;
    wait_nxt          = wait_r;
    ack_seen_nxt      = ack_seen_r;
    pre_mod_nxt       = pre_mod_r;
    frame_nxt         = frame_r;
    ri_nxt            = ri_r;
    done_kind_nxt     = done_kind_r;
    batch_frames_nxt  = batch_frames_r;
    max_attempts_nxt  = max_attempts_r;
    timeout_ticks_nxt = timeout_ticks_r;
    pre_trigger_nxt   = pre_trigger_r;
    out_nxt           = out_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    pop               = 1'b0;
    mod_req.start     = 1'b0;
    mod_req.x         = MOD_XW'(pre_trigger_r);

    if (cfg.we) begin
      case (cfg.index)
        REG_BATCH_FRAMES:  batch_frames_nxt  = cfg.wdata[4:0];
        REG_MAX_ATTEMPTS:  max_attempts_nxt  = cfg.wdata[3:0];
        REG_TIMEOUT_TICKS: timeout_ticks_nxt = cfg.wdata;
        REG_PRE_TRIGGER:   pre_trigger_nxt   = cfg.wdata[10:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (q.valid) begin
          pop     = 1'b1;
          cur_nxt = q.cmd;
          case (q.cmd.op)
            OP_START: begin
              mod_req.start = 1'b1;
              state_nxt     = S_PRE;
            end
            OP_NOCAP: begin
              active_nxt    = 1'b0;
              done_kind_nxt = KIND_NOCAP;
              state_nxt     = S_DONE;
            end
            OP_ACK: begin
              if (active_r) begin
                ack_seen_nxt   = seen_new;
                next_frame_nxt = nf_ack;
                if (nf_ack >= TOTAL) begin
                  active_nxt    = 1'b0;
                  done_kind_nxt = KIND_DONE;
                  state_nxt     = S_DONE;
                end else begin
                  batch_end_nxt = be_ack;
                  attempt_nxt   = 4'd1;
                  wait_nxt      = 16'd0;
                  mod_req.start = 1'b1;
                  state_nxt     = S_PRE;
                end
              end
            end
            OP_TICK: begin
              if (active_r) begin
                if (timeout) begin
                  wait_nxt = 16'd0;
                  if (attempt_r < lim_att) begin
                    attempt_nxt   = attempt_r + 4'd1;
                    mod_req.start = 1'b1;
                    state_nxt     = S_PRE;
                  end else begin
                    active_nxt    = 1'b0;
                    done_kind_nxt = KIND_DONE;
                    state_nxt     = S_DONE;
                  end
                end else begin
                  wait_nxt = wait_p1[15:0];
                end
              end
            end
            default: begin
              active_nxt = 1'b0;
            end
          endcase
        end
      end
      S_PRE: begin
        if (mod_rsp.done) begin
          pre_mod_nxt   = mod_rsp.r[RI_W-1:0];
          mod_req.start = 1'b1;
          if (cur_r.op == OP_START) begin
            mod_req.x = MOD_XW'(cur_r.trig);
            state_nxt = S_TRIG;
          end else begin
            mod_req.x = ri_x;
            state_nxt = S_RI;
          end
        end
      end
      S_TRIG: begin
        if (mod_rsp.done) begin
          ring_start_nxt = rs;
          active_nxt     = 1'b1;
          ack_seen_nxt   = 16'd0;
          next_frame_nxt = 8'd0;
          batch_end_nxt  = be_start;
          attempt_nxt    = 4'd1;
          wait_nxt       = 16'd0;
          frame_nxt      = 8'd0;
          ri_nxt         = rs;
          state_nxt      = S_HEAD;
        end
      end
      S_HEAD: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.kind  = KIND_START;
          out_nxt.total_frames = TOTAL;
          state_nxt     = S_FRAME;
        end
      end
      S_RI: begin
        if (mod_rsp.done) begin
          ri_nxt    = mod_rsp.r[RI_W-1:0];
          frame_nxt = next_frame_r;
          state_nxt = S_FRAME;
        end
      end
      S_FRAME: begin
        if (slot) begin
          out_valid_nxt               = 1'b1;
          out_nxt.kind                = KIND_FRAME;
          out_nxt.frame_number        = frame_r;
          out_nxt.sample_count        = cnt[3:0];
          out_nxt.first_ring_index    = 11'(ri_r);
          out_nxt.first_sample_offset = off[11:0];
          out_nxt.total_frames        = 8'd0;
          out_nxt.last                = last_frame;
          frame_nxt                   = frame_r + 8'd1;
          ri_nxt                      = ri_adv;
          if (last_frame) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DONE: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.kind  = done_kind_r;
          out_nxt.last  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      active_r        <= 1'b0;
      ring_start_r    <= '0;
      next_frame_r    <= 8'd0;
      batch_end_r     <= 8'd0;
      attempt_r       <= 4'd0;
      wait_r          <= 16'd0;
      ack_seen_r      <= 16'd0;
      batch_frames_r  <= RST_BATCH_FRAMES;
      max_attempts_r  <= RST_MAX_ATTEMPTS;
      timeout_ticks_r <= RST_TIMEOUT_TICKS;
      pre_trigger_r   <= RST_PRE_TRIGGER;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      active_r        <= active_nxt;
      ring_start_r    <= ring_start_nxt;
      next_frame_r    <= next_frame_nxt;
      batch_end_r     <= batch_end_nxt;
      attempt_r       <= attempt_nxt;
      wait_r          <= wait_nxt;
      ack_seen_r      <= ack_seen_nxt;
      batch_frames_r  <= batch_frames_nxt;
      max_attempts_r  <= max_attempts_nxt;
      timeout_ticks_r <= timeout_ticks_nxt;
      pre_trigger_r   <= pre_trigger_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    pre_mod_r   <= pre_mod_nxt;
    frame_r     <= frame_nxt;
    ri_r        <= ri_nxt;
    done_kind_r <= done_kind_nxt;
    out_r       <= out_nxt;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.kind                = out_r.kind;
  assign out_ch.frame_number        = out_r.frame_number;
  assign out_ch.sample_count        = out_r.sample_count;
  assign out_ch.first_ring_index    = out_r.first_ring_index;
  assign out_ch.first_sample_offset = $signed(out_r.first_sample_offset);
  assign out_ch.total_frames        = out_r.total_frames;
  assign out_ch.last                = out_r.last;

endmodule

// ===== rtl/core/bafs_checker.sv =====
// Port-level checks of the frame sender and their binding to the top level.
module bafs_checker import bafs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_frame_number,
  input logic [3:0] out_sample_count,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("ports not idle after reset");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_FRAME |-> out_frame_number == 8'd0 &&
      out_sample_count == 4'd0)
    else $error("status word carries frame fields");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_NOCAP) |-> out_last)
    else $error("done or no-capture word not marked last");

  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_START |-> !out_last)
    else $error("start status marked last");

endmodule

bind batched_ack_frame_sender_top bafs_checker u_bafs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_frame_number (out_ch.frame_number),
  .out_sample_count (out_ch.sample_count),
  .out_last         (out_ch.last)
);

// ===== tb/tb.sv =====
// Testbench for the batched acknowledged frame sender: directed and random words, predictor.
module tb;
  import bafs_pkg::*;

  localparam int RING_DEPTH        = 1920;
  localparam int SAMPLES_PER_FRAME = 8;
  localparam int FRAMES_RAW        = (RING_DEPTH + SAMPLES_PER_FRAME - 1) / SAMPLES_PER_FRAME;
  localparam int TOTAL_FRAMES      = (FRAMES_RAW > 255) ? 255 : FRAMES_RAW;
  localparam int IDLE_TAIL         = 40;
  localparam int STALL_LIMIT       = 4000;

  typedef struct packed {
    logic [1:0]  command;
    logic        has_capture;
    logic [10:0] trigger_index;
    logic        ack_has_last;
    logic [15:0] ack_last;
  } ctl_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_number;
    logic [3:0]  sample_count;
    logic [10:0] first_ring_index;
    logic [11:0] first_sample_offset;
    logic [7:0]  total_frames;
    logic        last;
  } result_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BATCH_FRAMES;
  logic [15:0] cfg_wdata = 16'd0;

  bafs_in_if  in_ch ();
  bafs_out_if out_ch ();

  batched_ack_frame_sender_top #(
    .RING_DEPTH        (RING_DEPTH),
    .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ctl_word_t    ctl_words[$];
  result_word_t due_results[$];
  ctl_word_t    cur_word;
  result_word_t held_result;
  bit           held_valid;
  bit           no_idle;
  int           queued_cnt;
  int           accepted_cnt;
  int           fail_cnt;
  int           in_gap;
  int           out_gap;
  int           out_draw;
  int           quiet_cycles;

  // predictor copy of registers and transfer state
  int r_batch    = RST_BATCH_FRAMES;
  int r_attempts = RST_MAX_ATTEMPTS;
  int r_timeout  = RST_TIMEOUT_TICKS;
  int r_pre      = RST_PRE_TRIGGER;
  int s_active, s_ring_start, s_next, s_end, s_attempt, s_wait, s_ack_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void emit_result(logic [1:0] kind, int fn, int cnt, int ri, int off,
                                      int tot);
    result_word_t r;
    r.kind                = kind;
    r.frame_number        = 8'(fn);
    r.sample_count        = 4'(cnt);
    r.first_ring_index    = 11'(ri);
    r.first_sample_offset = 12'(off);
    r.total_frames        = 8'(tot);
    r.last                = 1'b0;
    if (held_valid) due_results.push_back(held_result);
    held_result = r;
    held_valid  = 1'b1;
  endfunction

  function automatic void close_batch();
    int b;
    b = (r_batch < 1) ? 1 : ((r_batch > 16) ? 16 : r_batch);
    s_end = (s_next + b < TOTAL_FRAMES) ? s_next + b : TOTAL_FRAMES;
  endfunction

  function automatic void send_frames();
    int pre, fs, rem, cnt;
    pre = r_pre % RING_DEPTH;
    for (int f = s_next; f < s_end; f++) begin
      fs  = f * SAMPLES_PER_FRAME;
      rem = (fs < RING_DEPTH) ? RING_DEPTH - fs : 0;
      cnt = (rem < SAMPLES_PER_FRAME) ? rem : SAMPLES_PER_FRAME;
      emit_result(KIND_FRAME, f, cnt, (s_ring_start + fs) % RING_DEPTH, fs - pre, 0);
    end
    s_wait = 0;
  endfunction

  function automatic void apply_ctl_word(ctl_word_t w);
    int lim_att, lim_to;
    lim_att = (r_attempts < 1) ? 1 : r_attempts;
    lim_to  = (r_timeout < 1) ? 1 : r_timeout;
    case (w.command)
      CMD_START: begin
        if (!w.has_capture) begin
          s_active = 0;
          emit_result(KIND_NOCAP, 0, 0, 0, 0, 0);
        end else begin
          s_ring_start = (int'(w.trigger_index) % RING_DEPTH + RING_DEPTH - r_pre % RING_DEPTH)
                         % RING_DEPTH;
          s_active   = 1;
          s_ack_seen = 0;
          s_next     = 0;
          emit_result(KIND_START, 0, 0, 0, 0, TOTAL_FRAMES);
          close_batch();
          send_frames();
          s_attempt = 1;
        end
      end
      CMD_ACK: begin
        if (s_active) begin
          if (w.ack_has_last) s_ack_seen = w.ack_last;
          s_next = (s_ack_seen + 1 >= s_end) ? s_end : s_ack_seen + 1;
          if (s_next >= TOTAL_FRAMES) begin
            s_active = 0;
            emit_result(KIND_DONE, 0, 0, 0, 0, 0);
          end else begin
            close_batch();
            send_frames();
            s_attempt = 1;
          end
        end
      end
      CMD_TICK: begin
        if (s_active) begin
          if (s_wait + 1 >= lim_to) begin
            if (s_attempt < lim_att) begin
              send_frames();
              s_attempt = (s_attempt + 1) & 15;
            end else begin
              s_active = 0;
              s_wait   = 0;
              emit_result(KIND_DONE, 0, 0, 0, 0, 0);
            end
          end else begin
            s_wait = s_wait + 1;
          end
        end
      end
      default: s_active = 0;
    endcase
    if (held_valid) begin
      held_result.last = 1'b1;
      due_results.push_back(held_result);
      held_valid = 1'b0;
    end
  endfunction

  function automatic void cmp_field(string name, int e, int a);
    if (e != a) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
      fail_cnt++;
    end
  endfunction

  function automatic void check_result();
    result_word_t e;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected word expected none actual kind %0d frame %0d", $time,
               out_ch.kind, out_ch.frame_number);
      fail_cnt++;
    end else begin
      e = due_results.pop_front();
      cmp_field("kind", e.kind, out_ch.kind);
      cmp_field("frame_number", e.frame_number, out_ch.frame_number);
      cmp_field("sample_count", e.sample_count, out_ch.sample_count);
      cmp_field("first_ring_index", e.first_ring_index, out_ch.first_ring_index);
      cmp_field("first_sample_offset", $signed(e.first_sample_offset),
                $signed(out_ch.first_sample_offset));
      cmp_field("total_frames", e.total_frames, out_ch.total_frames);
      cmp_field("last", e.last, out_ch.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.command       <= CMD_DISC;
      in_ch.has_capture   <= 1'b0;
      in_ch.trigger_index <= '0;
      in_ch.ack_has_last  <= 1'b0;
      in_ch.ack_last      <= '0;
      in_gap              <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_ctl_word(cur_word);
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (ctl_words.size() > 0) begin
          cur_word            = ctl_words.pop_front();
          in_ch.command       <= cur_word.command;
          in_ch.has_capture   <= cur_word.has_capture;
          in_ch.trigger_index <= cur_word.trigger_index;
          in_ch.ack_has_last  <= cur_word.ack_has_last;
          in_ch.ack_last      <= cur_word.ack_last;
          in_ch.valid         <= 1'b1;
          in_gap              <= draw_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap      <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      check_result();
      out_draw = draw_gap();
      out_gap      <= out_draw;
      out_ch.ready <= (out_draw == 0);
    end else if (!out_ch.ready) begin
      if (out_gap > 0) begin
        out_gap      <= out_gap - 1;
        out_ch.ready <= (out_gap == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic put_word(logic [1:0] cmd, logic cap, logic [10:0] trig, logic hl,
                          logic [15:0] al);
    ctl_word_t w;
    w.command       = cmd;
    w.has_capture   = cap;
    w.trigger_index = trig;
    w.ack_has_last  = hl;
    w.ack_last      = al;
    ctl_words.push_back(w);
    queued_cnt++;
  endtask

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || due_results.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BATCH_FRAMES:  r_batch    = val[4:0];
      REG_MAX_ATTEMPTS:  r_attempts = val[3:0];
      REG_TIMEOUT_TICKS: r_timeout  = val;
      default:           r_pre      = val[10:0];
    endcase
  endtask

  task automatic plan_words(int n);
    int  made, eb, lto, latt, pos, ticks, steps, roll, cnt, span, al;
    bit  live, big;
    eb   = (r_batch < 1) ? 1 : ((r_batch > 16) ? 16 : r_batch);
    lto  = (r_timeout < 1) ? 1 : r_timeout;
    latt = (r_attempts < 1) ? 1 : r_attempts;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 80) begin
        put_word(CMD_START, 1'b1, 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                 16'($urandom_range(0, 65535)));
        made++;
        pos   = -1;
        ticks = 0;
        live  = 1'b1;
        big   = 1'b0;
        steps = $urandom_range(3, 45);
        while (live && steps > 0) begin
          steps--;
          roll = $urandom_range(0, 99);
          if (roll < 74) begin
            if (roll < 55) begin
              // advance within the batch
              pos = pos + (($urandom_range(0, 1) == 1) ? eb : $urandom_range(1, eb));
              if (pos > TOTAL_FRAMES - 1) pos = TOTAL_FRAMES - 1;
              al  = pos;
              big = 1'b0;
            end else if (roll < 62) begin
              // resend from a gap
              al  = $urandom_range(0, (pos < 0) ? 0 : pos);
              pos = al;
              big = 1'b0;
            end else if (roll < 68) begin
              al = $urandom_range(0, 65535);
              if (big) pos = (pos + eb > TOTAL_FRAMES - 1) ? TOTAL_FRAMES - 1 : pos + eb;
              else if (pos < 0) pos = 0;
            end else begin
              al  = $urandom_range(pos + eb, 65535);
              pos = (pos + eb > TOTAL_FRAMES - 1) ? TOTAL_FRAMES - 1 : pos + eb;
              big = 1'b1;
            end
            put_word(CMD_ACK, 1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                     (roll < 62 || roll >= 68), 16'(al));
            made++;
            ticks = 0;
            live  = (pos < TOTAL_FRAMES - 1);
          end else if (roll < 92) begin
            span = lto * latt - ticks;
            cnt  = $urandom_range(1, (span < 12) ? span : 12);
            repeat (cnt) begin
              put_word(CMD_TICK, 1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                       1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
              made++;
              ticks++;
            end
            live = (ticks < lto * latt);
          end else if (roll < 96) begin
            put_word(CMD_DISC, 1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                     1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
            made++;
            live = 1'b0;
          end else begin
            put_word(CMD_START, 1'b0, 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)));
            made++;
            live = 1'b0;
          end
        end
      end else begin
        put_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                 16'($urandom_range(0, 65535)));
        made++;
      end
    end
  endtask

  task automatic run_phase(int b, int att, int to, int pre, bit calm, int n);
    wait_idle();
    cfg_write(REG_BATCH_FRAMES, 16'(b));
    cfg_write(REG_MAX_ATTEMPTS, 16'(att));
    cfg_write(REG_TIMEOUT_TICKS, 16'(to));
    cfg_write(REG_PRE_TRIGGER, 16'(pre));
    no_idle = calm;
    plan_words(n);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // idle events, no capture, gaps, repeats and restarts
    put_word(CMD_ACK, 1'b0, 11'd0, 1'b1, 16'd0);
    put_word(CMD_TICK, 1'b0, 11'd0, 1'b0, 16'd0);
    put_word(CMD_DISC, 1'b0, 11'd0, 1'b0, 16'd0);
    put_word(CMD_START, 1'b0, 11'd0, 1'b0, 16'd0);
    put_word(CMD_START, 1'b1, 11'd0, 1'b0, 16'd0);
    put_word(CMD_ACK, 1'b0, 11'd0, 1'b0, 16'd0);
    put_word(CMD_ACK, 1'b0, 11'd0, 1'b1, 16'd3);
    put_word(CMD_ACK, 1'b0, 11'd0, 1'b1, 16'hFFFF);
    put_word(CMD_ACK, 1'b1, 11'h7FF, 1'b0, 16'd0);
    put_word(CMD_START, 1'b1, 11'd2047, 1'b0, 16'd0);
    put_word(CMD_START, 1'b1, 11'd1919, 1'b0, 16'd0);
    put_word(CMD_TICK, 1'b0, 11'd0, 1'b0, 16'd0);
    put_word(CMD_START, 1'b0, 11'd5, 1'b0, 16'd0);
    put_word(CMD_ACK, 1'b0, 11'd0, 1'b1, 16'd7);
    put_word(CMD_START, 1'b1, 11'd960, 1'b0, 16'd0);
    put_word(CMD_DISC, 1'b1, 11'd0, 1'b1, 16'd0);
    put_word(CMD_TICK, 1'b0, 11'd0, 1'b0, 16'd0);
    wait_idle();
    cfg_write(REG_TIMEOUT_TICKS, 16'd1);
    cfg_write(REG_MAX_ATTEMPTS, 16'd2);
    // resend on timeout, then abort
    put_word(CMD_START, 1'b1, 11'd1919, 1'b0, 16'd0);
    put_word(CMD_TICK, 1'b0, 11'd0, 1'b0, 16'd0);
    put_word(CMD_TICK, 1'b0, 11'd0, 1'b0, 16'd0);
    put_word(CMD_TICK, 1'b0, 11'd0, 1'b0, 16'd0);
    put_word(CMD_ACK, 1'b0, 11'd0, 1'b1, 16'd0);

    run_phase(16, 15, 1, 0, 1'b0, 68);
    run_phase(1, 1, 2, 1919, 1'b0, 68);
    run_phase(0, 0, 0, 2047, 1'b0, 68);
    run_phase(31, 2, 3, 1500, 1'b0, 68);
    run_phase(17, 7, 65535, 960, 1'b1, 68);
    run_phase($urandom_range(1, 16), $urandom_range(1, 15), $urandom_range(1, 4),
              $urandom_range(0, 2047), 1'b0, 68);
    run_phase($urandom_range(1, 16), $urandom_range(1, 15), $urandom_range(1, 4),
              $urandom_range(0, 2047), 1'b0, 68);
    wait_idle();

    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
